/* design/assert_macros.svh */
// Assertion macros shared by the modular inverse RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked check, active in every cycle including reset.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

/* design/mif_pkg.sv */
// Shared constants for the Fermat modular inverse block.
// No dependencies; used by the channel interfaces and the top level.
package mif_pkg;

    localparam int MODULUS_DEF = 3329;   // default prime modulus
    localparam int VALUE_W     = 16;     // signed input element
    localparam int INVERSE_W   = 12;     // result field width

endpackage

/* design/mif_channels.sv */
// Valid/ready channel interfaces for input elements and inverse results.
// Depends on mif_pkg for the payload widths.
interface mif_value_if;
    logic                                valid;
    logic                                ready;
    logic signed [mif_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface mif_inverse_if;
    logic                                valid;
    logic                                ready;
    logic [mif_pkg::INVERSE_W-1:0]       inverse;

    modport source (output valid, output inverse, input ready);
    modport sink   (input valid, input inverse, output ready);
endinterface

/* design/mif_modred.sv */
// Three-stage Barrett reduction of an unsigned XW-bit value by a constant modulus.
// No package dependencies; instantiated by mif_round and the top level.
module mif_modred #(
    parameter int MODULUS = 3329,
    parameter int XW      = 24,
    parameter int RW      = $clog2(MODULUS)
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [XW-1:0] i_x,
    output logic [RW-1:0] o_r
);

    localparam longint        MU   = (longint'(1) << XW) / MODULUS;
    localparam logic [XW-1:0] MU_V = XW'(MU);
    localparam logic [XW-1:0] M_V  = XW'(MODULUS);

    logic [XW-1:0]   r_x1;
    logic [2*XW-1:0] r_p1;
    logic [XW-1:0]   r_x2;
    logic [XW-1:0]   r_t2;
    logic [RW-1:0]   r_r3;

    logic [2*XW-1:0] n_qm;
    logic [XW-1:0]   n_diff;
    logic [RW:0]     n_rem;
    logic [RW-1:0]   n_r;

    // quotient estimate times modulus never exceeds x, so XW bits hold it
    assign n_qm   = (2*XW)'(r_p1[2*XW-1:XW]) * (2*XW)'(M_V);
    assign n_diff = r_x2 - r_t2;
    assign n_rem  = n_diff[RW:0];

    // remainder is below twice the modulus: one conditional subtract
    always_comb begin
        if (n_rem >= (RW+1)'(MODULUS)) begin
            n_r = RW'(n_rem - (RW+1)'(MODULUS));
        end else begin
            n_r = RW'(n_rem);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x1 <= i_x;
            r_p1 <= (2*XW)'(i_x) * (2*XW)'(MU_V);
            r_x2 <= r_x1;
            r_t2 <= n_qm[XW-1:0];
            r_r3 <= n_r;
        end
    end

    assign o_r = r_r3;

endmodule

/* design/mif_round.sv */
// One square-and-multiply round: product stage plus two parallel reductions.
// Depends on mif_modred; instantiated once per exponent bit by the top level.
module mif_round #(
    parameter int MODULUS = 3329,
    parameter int RW      = $clog2(MODULUS),
    parameter bit EXP_BIT = 1'b1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [RW-1:0] i_acc,
    input  logic [RW-1:0] i_sq,
    output logic          o_valid,
    output logic [RW-1:0] o_acc,
    output logic [RW-1:0] o_sq
);

    localparam int PW = 2*RW;

    logic [PW-1:0] r_pa;
    logic [PW-1:0] r_ps;
    logic [3:0]    r_v;

    // with a clear exponent bit the accumulator passes through unchanged
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (EXP_BIT) begin
                r_pa <= PW'(i_acc) * PW'(i_sq);
            end else begin
                r_pa <= PW'(i_acc);
            end
            r_ps <= PW'(i_sq) * PW'(i_sq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    mif_modred #(.MODULUS(MODULUS), .XW(PW), .RW(RW)) u_red_acc (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_x   (r_pa),
        .o_r   (o_acc)
    );

    mif_modred #(.MODULUS(MODULUS), .XW(PW), .RW(RW)) u_red_sq (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_x   (r_ps),
        .o_r   (o_sq)
    );

    assign o_valid = r_v[3];

endmodule

/* design/modular_inverse_fermat.sv */
// Throughput: one transaction per cycle while the skid entry is empty; one product stage and
// three Barrett reduction stages per round, all rounds laid out as a pipeline.
// A two-entry output stage keeps input ready high while one result waits.
// Reset is synchronous, active low, and clears only the valid bits.
`include "assert_macros.svh"

module modular_inverse_fermat #(
    parameter int MODULUS = mif_pkg::MODULUS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    mif_value_if.sink          i_value_ch,
    mif_inverse_if.source      o_inverse_ch
);

    // residue width, also the number of exponent bits (MODULUS-2 < 2**RW)
    localparam int            RW    = $clog2(MODULUS);
    localparam logic [RW-1:0] EXP   = RW'(MODULUS - 2);
    localparam int            OW    = mif_pkg::INVERSE_W;
    // offset: a multiple of MODULUS that lifts any signed input to >= 0
    localparam int            OFFS  = MODULUS * ((32768 + MODULUS - 1) / MODULUS);
    localparam int            UW    = mif_pkg::VALUE_W + 1;

    // ---------------------------------------------------------------
    // Pipeline enable: the whole pipe advances unless the skid entry
    // is occupied. Input ready is that same enable.
    // ---------------------------------------------------------------
    logic r_skid_v;
    logic w_en;

    assign w_en             = !r_skid_v;
    assign i_value_ch.ready = w_en;

    // ---------------------------------------------------------------
    // Input stage: add the offset so the element is non-negative.
    // ---------------------------------------------------------------
    logic signed [31:0] w_sum;
    logic [UW-1:0]      r_u0;
    logic               r_v0;

    assign w_sum = 32'(i_value_ch.value) + 32'(OFFS);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_u0 <= w_sum[UW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= i_value_ch.valid;
        end
    end

    // ---------------------------------------------------------------
    // Residue: Barrett reduction of the lifted value (three stages).
    // ---------------------------------------------------------------
    logic [RW-1:0] w_residue;
    logic [2:0]    r_vr;

    mif_modred #(.MODULUS(MODULUS), .XW(UW), .RW(RW)) u_red_in (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (r_u0),
        .o_r   (w_residue)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vr <= '0;
        end else if (w_en) begin
            r_vr <= {r_vr[1:0], r_v0};
        end
    end

    // ---------------------------------------------------------------
    // Square-and-multiply rounds, exponent scanned LSB first. Round g
    // multiplies into the accumulator only when exponent bit g is set.
    // ---------------------------------------------------------------
    logic [RW:0]   w_valid;
    logic [RW-1:0] w_acc [RW+1];
    logic [RW-1:0] w_sq  [RW+1];

    assign w_valid[0] = r_vr[2];
    assign w_acc[0]   = RW'(1);
    assign w_sq[0]    = w_residue;

    for (genvar g = 0; g < RW; g++) begin : g_round
        mif_round #(.MODULUS(MODULUS), .RW(RW), .EXP_BIT(EXP[g])) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[g]),
            .i_acc   (w_acc[g]),
            .i_sq    (w_sq[g]),
            .o_valid (w_valid[g+1]),
            .o_acc   (w_acc[g+1]),
            .o_sq    (w_sq[g+1])
        );
    end

    logic          w_pvalid;
    logic [RW-1:0] w_pacc;
    logic [OW-1:0] w_pinv;

    assign w_pvalid = w_valid[RW];
    assign w_pacc   = w_acc[RW];
    assign w_pinv   = OW'(w_pacc);   // masked or zero-extended to the result field

    // ---------------------------------------------------------------
    // Output register plus skid entry. A result arriving while the
    // output transaction is stalled parks in the skid entry, which in
    // turn freezes the pipe until the output drains.
    // ---------------------------------------------------------------
    logic          r_out_v;
    logic [OW-1:0] r_out_inv;
    logic [OW-1:0] r_skid_inv;
    logic          n_out_v;
    logic          n_skid_v;
    logic          w_hold;
    logic          w_arrive;

    assign w_hold   = r_out_v && !o_inverse_ch.ready;
    assign w_arrive = w_en && w_pvalid;

    always_comb begin
        n_out_v  = r_out_v;
        n_skid_v = r_skid_v;
        if (w_hold) begin
            if (w_arrive) begin
                n_skid_v = 1'b1;
            end
        end else if (r_skid_v) begin
            n_out_v  = 1'b1;
            n_skid_v = 1'b0;
        end else begin
            n_out_v = w_arrive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_hold) begin
            if (w_arrive) begin
                r_skid_inv <= w_pinv;
            end
        end else if (r_skid_v) begin
            r_out_inv <= r_skid_inv;
        end else if (w_arrive) begin
            r_out_inv <= w_pinv;
        end
    end

    assign o_inverse_ch.valid   = r_out_v;
    assign o_inverse_ch.inverse = r_out_inv;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `ASSERT_CLKD(a_skid_implies_out, i_clk, i_rst_n, r_skid_v |-> r_out_v, "skid full with output empty")
    `ASSERT_CLKD(a_stall_parks, i_clk, i_rst_n, (w_hold && w_arrive) |=> r_skid_v, "stalled result was dropped")
    `ASSERT_CLKD(a_skid_stable, i_clk, i_rst_n, (r_skid_v && w_hold) |=> (r_skid_v && $stable(r_skid_inv)), "skid entry changed while stalled")
    `ASSERT_CLKD(a_acc_range, i_clk, i_rst_n, w_pvalid |-> ((RW+1)'(w_pacc) < (RW+1)'(MODULUS)), "accumulator not reduced")

endmodule
